// File: rtl/matrix_multiply_4x4_core_assert.svh
// Assertion macros for the matrix multiply core.
`ifndef MATRIX_MULTIPLY_4X4_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mm4x4_pkg.sv
// Shared types and constants for the matrix multiply core.
`timescale 1ns / 1ps

package mm4x4_pkg;

	localparam int VAL_W = 32;
	localparam int IDX_W = 2;

	localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] OP_MULTIPLY   = 2'd2;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic signed [VAL_W-1:0] out_value;
		logic                    last;
	} rsp_item_t;

	// Tag that travels with each pair of operands read from the stores.
	typedef struct packed {
		logic             first;
		logic             last;
		logic             elem_last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} mm4x4_tag_t;

endpackage

// File: rtl/mm4x4_mem.sv
// Synchronous single-port-read matrix store with per-entry valid bits.
`timescale 1ns / 1ps

module mm4x4_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [mm4x4_pkg::VAL_W-1:0]  wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [mm4x4_pkg::VAL_W-1:0]  rdata
);

	logic signed [mm4x4_pkg::VAL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]                   vld_q;
	logic signed [mm4x4_pkg::VAL_W-1:0] rdata_q;
	logic                               rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	// An entry never written reads as zero.
	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/mm4x4_seq.sv
// Read sequencer: walks columns, rows and the inner index over both stores.
`timescale 1ns / 1ps

module mm4x4_seq #(
	parameter int DIM = 4,
	parameter int IW  = 2,
	parameter int AW  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  stall,
	output logic [AW-1:0]         left_addr,
	output logic [AW-1:0]         right_addr,
	output logic                  rd_en,
	output logic                  tag_vld_s1,
	output mm4x4_pkg::mm4x4_tag_t tag_s1,
	output logic                  busy
);

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'b01,
		SEQ_RUN  = 2'b10
	} seq_state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

	seq_state_t    state_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] r_q;
	logic [IW-1:0] c_q;
	logic          k_last;
	logic          r_last;
	logic          c_last;
	logic          issue;

	assign k_last = (k_q == LAST_IDX);
	assign r_last = (r_q == LAST_IDX);
	assign c_last = (c_q == LAST_IDX);
	assign issue  = (state_q == SEQ_RUN) && !stall;

	assign left_addr  = AW'(int'(r_q) * DIM + int'(k_q));
	assign right_addr = AW'(int'(k_q) * DIM + int'(c_q));
	assign rd_en      = !stall;
	assign busy       = (state_q == SEQ_RUN) || tag_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			k_q        <= '0;
			r_q        <= '0;
			c_q        <= '0;
			tag_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				SEQ_IDLE: begin
					if (start) begin
						state_q <= SEQ_RUN;
						k_q     <= '0;
						r_q     <= '0;
						c_q     <= '0;
					end
				end
				SEQ_RUN: begin
					if (issue) begin
						k_q <= k_last ? '0 : k_q + 1'b1;
						if (k_last) begin
							r_q <= r_last ? '0 : r_q + 1'b1;
							if (r_last) begin
								c_q <= c_last ? '0 : c_q + 1'b1;
								if (c_last) begin
									state_q <= SEQ_IDLE;
								end
							end
						end
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
			if (!stall) begin
				tag_vld_s1 <= (state_q == SEQ_RUN);
			end
		end
	end

	// Tag lines up with the registered read data of the stores.
	always_ff @(posedge clk) begin
		if (!stall) begin
			tag_s1.first     <= (k_q == '0);
			tag_s1.last      <= k_last;
			tag_s1.elem_last <= r_last && c_last;
			tag_s1.row       <= 2'(r_q);
			tag_s1.col       <= 2'(c_q);
		end
	end

endmodule

// File: rtl/mm4x4_mac.sv
// Multiply, accumulate, scale and saturate; holds the result register.
`timescale 1ns / 1ps

module mm4x4_mac #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tag_vld_s1,
	input  mm4x4_pkg::mm4x4_tag_t              tag_s1,
	input  logic signed [mm4x4_pkg::VAL_W-1:0] a_s1,
	input  logic signed [mm4x4_pkg::VAL_W-1:0] b_s1,
	output logic                               stall,
	output logic                               busy,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output mm4x4_pkg::rsp_item_t               rsp
);

	localparam int PW    = 2 * mm4x4_pkg::VAL_W;
	localparam int ACC_W = PW + $clog2(DIM);

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sh0000_0000_8000_0000);

	logic signed [PW-1:0]    p_s2;
	logic                    vld_s2;
	mm4x4_pkg::mm4x4_tag_t   tag_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic                    done_q;
	mm4x4_pkg::mm4x4_tag_t   tag_q;
	logic signed [ACC_W-1:0] scaled;
	logic signed [mm4x4_pkg::VAL_W-1:0] sat_val;

	// Hold the whole pipe while a finished element waits on a full output.
	assign stall = done_q && rsp_valid && !rsp_ready;
	assign busy  = vld_s2 || done_q;

	// Arithmetic shift floors the exact sum, then clamp to 32 bits.
	assign scaled = acc_q >>> FRAC_BITS;

	always_comb begin
		if (scaled > SAT_MAX) begin
			sat_val = SAT_MAX[mm4x4_pkg::VAL_W-1:0];
		end else if (scaled < SAT_MIN) begin
			sat_val = SAT_MIN[mm4x4_pkg::VAL_W-1:0];
		end else begin
			sat_val = scaled[mm4x4_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			p_s2   <= PW'(a_s1) * PW'(b_s1);
			tag_s2 <= tag_s1;
			if (vld_s2) begin
				acc_q <= tag_s2.first ? ACC_W'(p_s2) : acc_q + ACC_W'(p_s2);
				tag_q <= tag_s2;
			end
			if (done_q) begin
				rsp.out_row   <= tag_q.row;
				rsp.out_col   <= tag_q.col;
				rsp.out_value <= sat_val;
				rsp.last      <= tag_q.elem_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			done_q    <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (!stall) begin
				vld_s2 <= tag_vld_s1;
				done_q <= vld_s2 && tag_s2.last;
			end
			if (done_q && !stall) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/matrix_multiply_4x4_core.sv
// Square matrix multiplier over two element stores, signed Q16.16 fixed point.
//
// Command channel (cmd_valid / cmd_ready / cmd): load-left and load-right
// items write one element each, and loads back to back are
// accepted every cycle. Indexes outside the matrix and the unused opcode are
// accepted and dropped. A multiply item emits DIM*DIM elements on the
// result channel (rsp_valid / rsp_ready / rsp), columns outer, rows inner,
// with last set on the bottom-right element.
// Both stores have a single read port and the inner products are read one
// pair per cycle, while the pipe is not held, into a shared
// multiply-accumulate unit. cmd_ready stays low until every element of
// the multiply has reached the output register.
// Reset clears both stores to zero through per-entry valid bits; the block
// accepts items right after reset. When the receiver stalls, the finished
// element waits in the output register while the pipe runs on; once the
// next element is finished, the whole read and accumulate pipe holds until
// the waiting item is taken.
`timescale 1ns / 1ps

`include "matrix_multiply_4x4_core_assert.svh"

module matrix_multiply_4x4_core #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  mm4x4_pkg::cmd_item_t cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mm4x4_pkg::rsp_item_t rsp
);

	localparam int DEPTH = DIM * DIM;
	localparam int IW    = $clog2(DIM);
	localparam int AW    = $clog2(DEPTH);

	logic                               cmd_acc;
	logic                               in_range;
	logic [AW-1:0]                      waddr;
	logic                               we_left;
	logic                               we_right;
	logic                               start;
	logic                               stall;
	logic                               seq_busy;
	logic                               mac_busy;
	logic                               rd_en;
	logic [AW-1:0]                      left_addr;
	logic [AW-1:0]                      right_addr;
	logic                               tag_vld_s1;
	mm4x4_pkg::mm4x4_tag_t              tag_s1;
	logic signed [mm4x4_pkg::VAL_W-1:0] a_s1;
	logic signed [mm4x4_pkg::VAL_W-1:0] b_s1;

	// Interlock: no new item while a multiply still reads the stores or has work in the accumulate pipe.
	assign cmd_ready = !seq_busy && !mac_busy;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign in_range  = (int'(cmd.row) < DIM) && (int'(cmd.col) < DIM);
	assign waddr     = AW'(int'(cmd.row) * DIM + int'(cmd.col));
	assign we_left   = cmd_acc && in_range && (cmd.opcode == mm4x4_pkg::OP_LOAD_LEFT);
	assign we_right  = cmd_acc && in_range && (cmd.opcode == mm4x4_pkg::OP_LOAD_RIGHT);
	assign start     = cmd_acc && (cmd.opcode == mm4x4_pkg::OP_MULTIPLY);

	mm4x4_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_left),
		.waddr  (waddr),
		.wdata  (cmd.value),
		.re     (rd_en),
		.raddr  (left_addr),
		.rdata  (a_s1)
	);

	mm4x4_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_right),
		.waddr  (waddr),
		.wdata  (cmd.value),
		.re     (rd_en),
		.raddr  (right_addr),
		.rdata  (b_s1)
	);

	mm4x4_seq #(
		.DIM (DIM),
		.IW  (IW),
		.AW  (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.stall      (stall),
		.left_addr  (left_addr),
		.right_addr (right_addr),
		.rd_en      (rd_en),
		.tag_vld_s1 (tag_vld_s1),
		.tag_s1     (tag_s1),
		.busy       (seq_busy)
	);

	mm4x4_mac #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag_vld_s1 (tag_vld_s1),
		.tag_s1     (tag_s1),
		.a_s1       (a_s1),
		.b_s1       (b_s1),
		.stall      (stall),
		.busy       (mac_busy),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	`MM_ASSERT_NEXT(a_mul_blocks, start, !cmd_ready, "multiply did not block the command channel")
	`MM_ASSERT_NEXT(a_load_free, cmd_acc && !start, cmd_ready, "load left the block busy")
	`MM_ASSERT_NOW(a_stall_full, stall, rsp_valid && !rsp_ready, "pipe held without a waiting item")
	`MM_ASSERT_NOW(a_last_pos, rsp_valid && rsp.last, (rsp.out_row == 2'(DIM - 1)) && (rsp.out_col == 2'(DIM - 1)), "last flag on wrong element")

endmodule
